// ----- design/usa_pkg.sv -----
package usa_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned OUT_CNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_FINISH
  } state_e;

  // enables from the sequencer to the key store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ----- design/usa_key_mem.sv -----
module usa_key_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                    clk_i,
  input  usa_pkg::mem_ctl_t       ctl_i,
  input  logic [AW-1:0]           rd_addr_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic [usa_pkg::KEY_W-1:0] wr_data_i,
  output logic [usa_pkg::KEY_W-1:0] rd_data_o
);
  import usa_pkg::*;

  logic [KEY_W-1:0] mem_q [DEPTH];
  logic [KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/usa_ctrl.sv -----
module usa_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [usa_pkg::CMD_W-1:0]  cmd_i,
  input  logic [usa_pkg::KEY_W-1:0]  key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       was_member_o,
  output logic                       accepted_o,
  output logic [usa_pkg::OUT_CNT_W-1:0] count_after_o,
  output logic                       is_full_o,
  output logic                       is_empty_o,
  output usa_pkg::mem_ctl_t          mem_ctl_o,
  output logic [AW-1:0]              rd_addr_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [usa_pkg::KEY_W-1:0]  wr_data_o,
  input  logic [usa_pkg::KEY_W-1:0]  rd_data_i
);
  import usa_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             found_q, found_d;
  logic [AW-1:0]    slot_q, slot_d;

  logic             out_vld_q, out_vld_d;
  logic             member_q, member_d;
  logic             acc_q, acc_d;
  logic [CW-1:0]    out_cnt_q, out_cnt_d;

  logic             hit, last_cmp, issue, fin_load;
  logic [CW-1:0]    cnt_last;

  assign cnt_last = cnt_q - ONE_C;
  assign hit      = cmp_vld_q && (rd_data_i == key_q);
  assign last_cmp = cmp_vld_q && (CW'(cmp_idx_q) == cnt_last);
  assign issue    = rd_idx_q < cnt_q;
  assign fin_load = (state_q == ST_FINISH) && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    found_q   <= found_d;
    slot_q    <= slot_d;
    member_q  <= member_d;
    acc_q     <= acc_d;
    out_cnt_q <= out_cnt_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    slot_d    = slot_q;
    member_d  = member_q;
    acc_d     = acc_q;
    out_cnt_d = out_cnt_q;
    out_vld_d = out_vld_q && out_stall_i;
    in_stall_o       = 1'b1;
    mem_ctl_o.rd_en  = 1'b0;
    mem_ctl_o.wr_en  = 1'b0;
    rd_addr_o        = rd_idx_q[AW-1:0];
    wr_addr_o        = cnt_q[AW-1:0];
    wr_data_o        = key_q;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d     = cmd_e'(cmd_i);
          key_d     = key_i;
          rd_idx_d  = '0;
          cmp_vld_d = 1'b0;
          found_d   = 1'b0;
          state_d   = (cnt_q == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read one entry and compare the previous one each cycle
        mem_ctl_o.rd_en = issue;
        cmp_vld_d       = issue;
        cmp_idx_d       = rd_idx_q[AW-1:0];
        rd_idx_d        = rd_idx_q + CW'(issue);
        if (hit) begin
          found_d   = 1'b1;
          slot_d    = cmp_idx_q;
          cmp_vld_d = 1'b0;
          state_d   = (cmd_q == CMD_DELETE) ? ST_MOVE : ST_FINISH;
        end else if (last_cmp) begin
          cmp_vld_d = 1'b0;
          state_d   = ST_FINISH;
        end
      end
      ST_MOVE: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = cnt_last[AW-1:0];
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_load) begin
          member_d = found_q;
          acc_d    = 1'b0;
          case (cmd_q)
            CMD_INSERT: begin
              if (!found_q && (cnt_q != DEPTH_C)) begin
                acc_d           = 1'b1;
                mem_ctl_o.wr_en = 1'b1;
                cnt_d           = cnt_q + ONE_C;
              end
            end
            CMD_DELETE: begin
              if (found_q) begin
                acc_d           = 1'b1;
                mem_ctl_o.wr_en = 1'b1;
                wr_addr_o       = slot_q;
                wr_data_o       = rd_data_i;
                cnt_d           = cnt_last;
              end
            end
            CMD_CLEAR: cnt_d = '0;
            default: ;
          endcase
          out_cnt_d = cnt_d;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o   = out_vld_q;
  assign was_member_o  = member_q;
  assign accepted_o    = acc_q;
  assign count_after_o = OUT_CNT_W'(out_cnt_q);
  assign is_full_o     = out_cnt_q == DEPTH_C;
  assign is_empty_o    = out_cnt_q == '0;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C) else $error("entry count beyond depth");

  a_ins_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && acc_d && cmd_q == CMD_INSERT) |=> cnt_q == $past(cnt_q) + ONE_C)
    else $error("insert did not grow count");

  a_del_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && acc_d && cmd_q == CMD_DELETE) |=> cnt_q == $past(cnt_q) - ONE_C)
    else $error("delete did not shrink count");

  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmp_vld_q) |-> CW'(cmp_idx_q) < cnt_q)
    else $error("compare beyond filled entries");

endmodule

// ----- design/unordered_array_set_unit.sv -----
// Unordered set of distinct 32-bit keys held in a table of DEPTH entries.
// Input channel (in_valid_i / in_stall_o) carries cmd_i and key_i; a transfer
// happens on a rising edge with valid high and stall low. cmd_i: insert,
// delete, membership query or clear. Exactly one result per request leaves on
// the output channel (out_valid_o / out_stall_i): was_member_o, accepted_o,
// count_after_o, is_full_o, is_empty_o.
// Operation: one key comparator walks the table, one stored entry per cycle,
// fed by the table's single registered read port. A delete that hits
// re-reads the last entry to fill the hole. The input stalls from the
// transfer until the sequencer is back in idle, so a new request is taken
// only after the last one has reached the result register; an empty table
// skips the walk.
// The result sits in an output register: the next request is taken while it
// waits, and when out_stall_i is held the following result waits in its
// final step, with nothing lost or repeated.
// Reset (rst_ni, asynchronous, active low) empties the set and idles the
// sequencer; table contents are not cleared, only entries below the count
// are ever read.
module unordered_array_set_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [usa_pkg::CMD_W-1:0]     cmd_i,
  input  logic signed [usa_pkg::KEY_W-1:0] key_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          was_member_o,
  output logic                          accepted_o,
  output logic [usa_pkg::OUT_CNT_W-1:0] count_after_o,
  output logic                          is_full_o,
  output logic                          is_empty_o
);
  import usa_pkg::*;

  // table index and count widths
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data, rd_data;
  logic [KEY_W-1:0] key_raw;

  assign key_raw = key_i;

  // sequencer with the shared comparator and the result register
  usa_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_i         (key_raw),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .was_member_o  (was_member_o),
    .accepted_o    (accepted_o),
    .count_after_o (count_after_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o),
    .mem_ctl_o     (mem_ctl),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_data_i     (rd_data)
  );

  // key table: one write port, one registered read port
  usa_key_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_key_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule
